FILE: hw/rtl/recent_multicast_duplicate_filter_macros.svh
// Assertion helpers shared by the filter modules.
`ifndef RECENT_MULTICAST_DUPLICATE_FILTER_MACROS_SVH
`define RECENT_MULTICAST_DUPLICATE_FILTER_MACROS_SVH

// Check a property while out of reset.
`define RMDF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define RMDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/rmdf_pkg.sv
package rmdf_pkg;

    // Bucket count must be a power of two: the index is the low sequence bits.
    localparam int BUCKETS = 256;
    localparam int WAYS    = 4;

    localparam int IDX_W  = $clog2(BUCKETS);
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W  = $clog2(WAYS + 1);

    localparam int TICK_W = 32;
    localparam int SEQ_W  = 32;
    localparam int ADDR_W = 48;
    localparam int LIFE_W = 24;

    localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(300);

    typedef struct packed {
        logic              valid;
        logic [SEQ_W-1:0]  seq;
        logic [ADDR_W-1:0] addr;
        logic [TICK_W-1:0] expiry;
    } slot_t;

    typedef slot_t [WAYS-1:0] row_t;

    typedef struct packed {
        logic load_in;
        logic rd_en;
        logic walk_en;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
    } status_t;

endpackage

FILE: hw/rtl/rmdf_ctrl.sv
`include "recent_multicast_duplicate_filter_macros.svh"

module rmdf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  rmdf_pkg::status_t status,
    output rmdf_pkg::cmd_t   cmd
);
    import rmdf_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_WALK   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        cmd         = '0;
        cmd.load_in = accept;
        cmd.rd_en   = (state_reg == ST_READ);
        cmd.walk_en = (state_reg == ST_WALK);
        cmd.commit  = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (status.walk_done) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (cmd.commit) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `RMDF_ASSERT(a_accept_reads, aclk, aresetn, accept |=> (state_reg == ST_READ), "accept did not start a bucket read")
    `RMDF_ASSERT(a_result_from_commit, aclk, aresetn, $rose(out_valid_reg) |-> $past(cmd.commit), "result raised without a commit")

endmodule

FILE: hw/rtl/rmdf_datapath.sv
`include "recent_multicast_duplicate_filter_macros.svh"

module rmdf_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [rmdf_pkg::LIFE_W-1:0]   cfg_lifetime,
    input  logic [rmdf_pkg::TICK_W-1:0]   in_now,
    input  logic [rmdf_pkg::SEQ_W-1:0]    in_seq,
    input  logic [rmdf_pkg::ADDR_W-1:0]   in_addr,
    input  rmdf_pkg::cmd_t                cmd,
    output rmdf_pkg::status_t             status,
    output logic                          is_duplicate
);
    import rmdf_pkg::*;

    row_t mem [BUCKETS];

    logic [LIFE_W-1:0]  lifetime_reg;
    logic [TICK_W-1:0]  now_reg;
    logic [SEQ_W-1:0]   seq_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [BUCKETS-1:0] bucket_live_reg;
    row_t               row_reg;
    logic               row_live_reg;
    slot_t              buf_reg [WAYS];
    logic [WAY_W-1:0]   w_reg;
    logic [CNT_W-1:0]   kept_reg;
    logic               dup_reg;
    logic               result_reg;

    logic [IDX_W-1:0]   bucket_idx;
    slot_t              cur;
    logic               cur_valid;
    logic [TICK_W-1:0]  diff;
    logic               expired;
    logic               hit;
    logic               last_way;
    logic               full_skip;
    logic               take;
    logic               set_dup;
    slot_t              new_slot;
    row_t               wr_row;

    assign bucket_idx = seq_reg[IDX_W-1:0];

    // One way per cycle, newest first.
    assign cur       = row_reg[w_reg];
    assign cur_valid = row_live_reg && cur.valid;
    assign diff      = cur.expiry - now_reg;
    assign expired   = diff[TICK_W-1];
    assign hit       = (cur.seq == seq_reg) && (cur.addr == addr_reg);
    assign last_way  = (w_reg == WAY_W'(WAYS - 1));
    assign full_skip = ((kept_reg + CNT_W'(1)) == CNT_W'(WAYS));
    assign take      = cur_valid && (dup_reg || (!expired && !full_skip));
    assign set_dup   = cur_valid && !dup_reg && !expired && !full_skip && hit;

    assign status.walk_done = !cur_valid || last_way;
    assign is_duplicate     = result_reg;

    always_comb begin
        new_slot        = '0;
        new_slot.valid  = 1'b1;
        new_slot.seq    = seq_reg;
        new_slot.addr   = addr_reg;
        new_slot.expiry = now_reg + {{(TICK_W - LIFE_W){1'b0}}, lifetime_reg};
    end

    // Pack survivors behind the new head, or from the head on a duplicate.
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            if (dup_reg) begin
                wr_row[i]       = buf_reg[i];
                wr_row[i].valid = (CNT_W'(i) < kept_reg);
            end else if (i == 0) begin
                wr_row[i] = new_slot;
            end else begin
                wr_row[i]       = buf_reg[(i > 0) ? i - 1 : 0];
                wr_row[i].valid = (CNT_W'(i - 1) < kept_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) mem[bucket_idx] <= wr_row;
        if (cmd.rd_en)  row_reg <= mem[bucket_idx];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            now_reg  <= in_now;
            seq_reg  <= in_seq;
            addr_reg <= in_addr;
        end
        if (cmd.rd_en) row_live_reg <= bucket_live_reg[bucket_idx];
        if (cmd.walk_en && take) buf_reg[kept_reg[WAY_W-1:0]] <= cur;
        if (cmd.commit) result_reg <= dup_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lifetime_reg    <= LIFETIME_RESET;
            bucket_live_reg <= '0;
            w_reg           <= '0;
            kept_reg        <= '0;
            dup_reg         <= 1'b0;
        end else begin
            if (cfg_we) lifetime_reg <= cfg_lifetime;
            if (cmd.commit) bucket_live_reg[bucket_idx] <= 1'b1;
            if (cmd.rd_en) begin
                w_reg    <= '0;
                kept_reg <= '0;
                dup_reg  <= 1'b0;
            end else if (cmd.walk_en) begin
                if (!last_way) w_reg <= w_reg + WAY_W'(1);
                if (take)      kept_reg <= kept_reg + CNT_W'(1);
                if (set_dup)   dup_reg <= 1'b1;
            end
        end
    end

    `RMDF_ASSERT(a_new_fits, aclk, aresetn, (cmd.commit && !dup_reg) |-> (kept_reg < CNT_W'(WAYS)), "insert would overflow the bucket")
    `RMDF_ASSERT(a_bucket_marked, aclk, aresetn, cmd.commit |=> bucket_live_reg[$past(bucket_idx)], "written bucket not marked live")

endmodule

FILE: hw/rtl/recent_multicast_duplicate_filter.sv
// Recent multicast duplicate filter.
// Input channel s_*: one transfer per received frame carrying the current
// tick count, the sequence number and the source address. Result channel m_*:
// one transfer per frame, bit 0 set when the frame was seen recently and is
// still live in the cache; otherwise the frame is now cached.
// Configuration channel cfg_*: writes the entry lifetime in ticks; always ready,
// write it only while the filter is idle.
// Each accepted frame has its bucket read, then k ways walked (1 to WAYS,
// one per cycle) by the datapath comparator, then its result registered
// together with the single-port write-back. No new frame is accepted
// until the current one has been written back.
// The cache holds BUCKETS rows of WAYS entries in one memory; a live flag per
// row, cleared at reset, masks rows never written, so no clearing pass runs.
// Reset: lifetime returns to 300, every bucket reads empty, no result pending.
// A stalled receiver holds the result in the output register; the next frame
// is still accepted and walked, and waits for write-back until the result
// is taken.
module recent_multicast_duplicate_filter (
    input  logic         aclk,
    input  logic         aresetn,
    // now_ticks [31:0], seq_number [63:32], src_addr [111:64]
    input  logic [111:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // is_duplicate [0], zero fill [7:1]
    output logic [7:0]   m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // entry_lifetime [23:0]
    input  logic [23:0]  cfg_tdata,
    input  logic         cfg_tvalid,
    output logic         cfg_tready
);
    import rmdf_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    is_dup;

    // Lifetime register takes a write every cycle.
    assign cfg_tready = 1'b1;
    assign m_tdata    = {7'd0, is_dup};

    rmdf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rmdf_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_tvalid),
        .cfg_lifetime (cfg_tdata),
        .in_now       (s_tdata[31:0]),
        .in_seq       (s_tdata[63:32]),
        .in_addr      (s_tdata[111:64]),
        .cmd          (cmd),
        .status       (status),
        .is_duplicate (is_dup)
    );

endmodule
